FILE: rtl/stk_pkg.sv
package stk_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int CNTF_W  = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNTF_W-1:0]        cntf_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_TOP    = 3'd2,
    OP_BOTTOM = 3'd3,
    OP_PEEK   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADPOS   = 2'd3
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  typedef struct packed {
    word_t   read_data;
    status_e status;
    logic    is_empty;
    logic    is_full;
    cntf_t   entry_count;
  } rsp_t;

endpackage

FILE: rtl/stk_ifs.sv
interface stk_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [stk_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

interface stk_req_if;
  logic                        valid;
  logic                        ready;
  logic [stk_pkg::OP_W-1:0]    opcode;
  logic signed [stk_pkg::DATA_W-1:0] push_value;
  logic [stk_pkg::POS_W-1:0]   position;

  modport source (output valid, output opcode, output push_value, output position,
                  input ready);
  modport sink (input valid, input opcode, input push_value, input position,
                output ready);
endinterface

interface stk_rsp_if;
  logic                        valid;
  logic                        ready;
  logic signed [stk_pkg::DATA_W-1:0] read_data;
  logic [1:0]                  status;
  logic                        is_empty;
  logic                        is_full;
  logic [stk_pkg::CNTF_W-1:0]  entry_count;

  modport source (output valid, output read_data, output status, output is_empty,
                  output is_full, output entry_count, input ready);
  modport sink (input valid, input read_data, input status, input is_empty,
                input is_full, input entry_count, output ready);
endinterface

FILE: rtl/stk_cell.sv
module stk_cell (
  input  logic            clk_i,
  input  stk_pkg::shift_t shift_i,
  input  stk_pkg::word_t  upper_i,
  input  stk_pkg::word_t  lower_i,
  output stk_pkg::word_t  data_o
);

  stk_pkg::word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i.push) begin
      data_d = upper_i;
    end else if (shift_i.pop) begin
      data_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/array_stack_with_peek_unit.sv
// LIFO stack of signed words held in a row of cells, cell 0 being the top: a push
// shifts every cell one place down and a pop one place up; one operation is taken
// every cycle while the result register is free or being drained. The result
// appears in the cycle after the request transaction. The user must write capacity
// on the configuration channel only while the stack is idle; the block does not
// enforce this. 0 behaves as 1 and values above the cell count as the cell count.
// Reading the bottom or peeking selects one cell through a single read multiplexer.
module array_stack_with_peek_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  stk_cfg_if.sink    cfg_i,
  stk_req_if.sink    req_i,
  stk_rsp_if.source  rsp_o
);

  logic [stk_pkg::CAP_W-1:0] cap_q;
  stk_pkg::cnt_t             cnt_q, cnt_d;
  stk_pkg::cnt_t             eff_cap;
  stk_pkg::rsp_t             rsp_q, rsp_d;
  logic                      rsp_valid_q;
  logic                      fire;
  logic                      full, empty;
  stk_pkg::shift_t           shift;
  stk_pkg::idx_t             rd_idx;
  stk_pkg::word_t            rd_word;
  stk_pkg::word_t            cell_data [stk_pkg::DEPTH];

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = stk_pkg::cnt_t'(1);
    end else if (int'(cap_q) > stk_pkg::DEPTH) begin
      eff_cap = stk_pkg::cnt_t'(stk_pkg::DEPTH);
    end else begin
      eff_cap = stk_pkg::cnt_t'(cap_q);
    end
  end

  assign full  = cnt_q >= eff_cap;
  assign empty = cnt_q == '0;

  for (genvar g = 0; g < stk_pkg::DEPTH; g++) begin : g_cell
    stk_pkg::word_t upper, lower;
    if (g == 0) begin : g_top
      assign upper = req_i.push_value;
    end else begin : g_mid
      assign upper = cell_data[g-1];
    end
    if (g == stk_pkg::DEPTH - 1) begin : g_last
      assign lower = cell_data[g];
    end else begin : g_inner
      assign lower = cell_data[g+1];
    end
    stk_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .upper_i (upper),
      .lower_i (lower),
      .data_o  (cell_data[g])
    );
  end

  assign rd_word = cell_data[rd_idx];

  always_comb begin
    shift             = '0;
    cnt_d             = cnt_q;
    rd_idx            = '0;
    rsp_d.read_data   = '0;
    rsp_d.status      = stk_pkg::ST_OK;
    case (stk_pkg::op_e'(req_i.opcode))
      stk_pkg::OP_PUSH: begin
        if (full) begin
          rsp_d.status = stk_pkg::ST_OVERFLOW;
        end else begin
          shift.push = fire;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      stk_pkg::OP_POP, stk_pkg::OP_TOP, stk_pkg::OP_BOTTOM: begin
        if (req_i.opcode == stk_pkg::OP_BOTTOM) begin
          rd_idx = stk_pkg::idx_t'(cnt_q - 1'b1);
        end
        if (empty) begin
          rsp_d.status    = stk_pkg::ST_EMPTY;
          rsp_d.read_data = '1;
        end else begin
          rsp_d.read_data = rd_word;
          if (req_i.opcode == stk_pkg::OP_POP) begin
            shift.pop = fire;
            cnt_d     = cnt_q - 1'b1;
          end
        end
      end
      stk_pkg::OP_PEEK: begin
        rd_idx = stk_pkg::idx_t'(req_i.position - 1'b1);
        if (req_i.position == '0 || int'(req_i.position) > int'(cnt_q)) begin
          rsp_d.status    = stk_pkg::ST_BADPOS;
          rsp_d.read_data = '1;
        end else begin
          rsp_d.read_data = rd_word;
        end
      end
      default: begin
      end
    endcase
    rsp_d.is_empty    = cnt_d == '0;
    rsp_d.is_full     = cnt_d >= eff_cap;
    rsp_d.entry_count = stk_pkg::cntf_t'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= stk_pkg::CAP_W'(16);
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
      if (fire) begin
        cnt_q       <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_q.read_data;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.is_empty    = rsp_q.is_empty;
  assign rsp_o.is_full     = rsp_q.is_full;
  assign rsp_o.entry_count = rsp_q.entry_count;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= stk_pkg::DEPTH)
    else $error("entry count beyond cell count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift.push |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not advance the count");

  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift.push |=> cell_data[0] == $past(req_i.push_value))
    else $error("pushed word not at the top cell");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift.pop |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("pop did not drop the count");

  a_rsp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_valid_q && rsp_q.entry_count == stk_pkg::cntf_t'(cnt_q))
    else $error("result missing or count mismatch after request");
`endif

endmodule
